### src/rkg_pkg.sv
// rkg_pkg: shared types, constants and controller states for the rsa key generator
// no dependencies
`default_nettype none
package rkg_pkg;

  localparam int unsigned PRIME_BITS_DEF = 16;
  localparam logic [16:0] EXP_DEFAULT = 17'd65537;
  localparam logic [16:0] EXP_SMALL = 17'd3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_PRIME = 2'd1,
    ST_NO_INV    = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] prime_q;
    logic [15:0] prime_p;
  } in_item_t;

  typedef struct packed {
    logic [31:0] private_exponent;
    logic [16:0] public_exponent;
    logic [31:0] modulus;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PR_INIT,
    S_PR_SMALL,
    S_PR_DIV,
    S_PR_WAIT,
    S_PR_NEXT,
    S_MUL,
    S_E_INIT,
    S_GCD_DIV,
    S_GCD_WAIT,
    S_INV_INIT,
    S_INV_DIV,
    S_INV_WAIT,
    S_INV_T,
    S_INV_FIX,
    S_DONE_OK,
    S_DONE_NP,
    S_DONE_NI
  } ctl_state_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PR_SEL,
    OP_PR_START,
    OP_PR_NEXT,
    OP_MUL,
    OP_E_INIT,
    OP_GCD_START,
    OP_GCD_STEP,
    OP_E_BUMP,
    OP_INV_INIT,
    OP_INV_START,
    OP_INV_STEP,
    OP_INV_T,
    OP_INV_FIX
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   pr_second;
    logic   divk2;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic pr_small_prime;
    logic pr_small_comp;
    logic pr_loop_end;
    logic rem_zero;
    logic gcd_b_zero;
    logic gcd_is_one;
    logic inv_r1_zero;
    logic inv_ok;
  } dp_status_t;

endpackage
`default_nettype wire

### src/rkg_divider.sv
// rkg_divider: radix-2 restoring divider, one quotient bit per cycle
// uses rkg_pkg for nothing; standalone
`default_nettype none
module rkg_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [WIDTH-1:0]      remainder
);
  localparam int unsigned CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    count;
  logic             running;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   shifted;

  assign shifted = {remainder, quotient[WIDTH-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CW'(WIDTH);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (running) begin
      if (!trial[WIDTH]) begin
        remainder <= trial[WIDTH-1:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b1};
      end else begin
        remainder <= shifted[WIDTH-1:0];
        quotient  <= {quotient[WIDTH-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### src/rkg_datapath.sv
// rkg_datapath: operand registers, shared divider, multiplier and Euclid registers
// depends on rkg_pkg and rkg_divider
`default_nettype none
module rkg_datapath #(
  parameter int unsigned PRIME_BITS = rkg_pkg::PRIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rkg_pkg::in_item_t   in_item,
  input  wire rkg_pkg::dp_cmd_t    cmd,
  output rkg_pkg::dp_status_t      sts,
  output logic [31:0]              modulus,
  output logic [16:0]              public_exponent,
  output logic [31:0]              private_exponent
);
  import rkg_pkg::*;

  localparam logic [15:0] MASK = 16'((32'd1 << PRIME_BITS) - 32'd1);

  logic [15:0] p, q, v;
  logic [16:0] k;
  logic [33:0] ksq;
  logic [31:0] phi;
  logic [16:0] e;
  logic [31:0] ga, gb;
  logic [31:0] r0, r1;
  logic signed [33:0] t0, t1;
  logic [31:0] qt;
  logic signed [67:0] prod;

  logic        div_start;
  logic [31:0] div_a, div_b, div_q, div_r;
  logic        div_done;
  logic        v_mult3;

  // 4 is 1 mod 3, so the sum of 2-bit digits keeps the residue
  function automatic logic is_mult3(input logic [15:0] x);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    s1 = '0;
    for (int i = 0; i < 8; i++) s1 = s1 + 5'(x[2*i +: 2]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    return (s3 == 3'd0) || (s3 == 3'd3);
  endfunction

  rkg_divider #(.WIDTH(32)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_comb begin
    div_start = 1'b0;
    div_a = {16'd0, v};
    div_b = cmd.divk2 ? 32'(k + 17'd2) : 32'(k);
    case (cmd.op)
      OP_PR_START: div_start = 1'b1;
      OP_GCD_START: begin
        div_start = 1'b1;
        div_a = ga;
        div_b = gb;
      end
      OP_INV_START: begin
        div_start = 1'b1;
        div_a = r0;
        div_b = r1;
      end
      default: ;
    endcase
  end

  assign prod = t1 * $signed({2'b00, qt});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        p <= in_item.prime_p & MASK;
        q <= in_item.prime_q & MASK;
      end
      OP_PR_SEL: begin
        v   <= cmd.pr_second ? q : p;
        k   <= 17'd5;
        ksq <= 34'd25;
      end
      OP_PR_NEXT: begin
        k   <= k + 17'd6;
        ksq <= ksq + 34'({k, 3'b000}) + 34'({k, 2'b00}) + 34'd36;
      end
      OP_MUL: begin
        modulus <= 32'(p) * 32'(q);
        phi     <= 32'(p - 16'd1) * 32'(q - 16'd1);
      end
      OP_E_INIT: e <= (32'(EXP_DEFAULT) >= phi) ? EXP_SMALL : EXP_DEFAULT;
      OP_GCD_START: ;
      OP_GCD_STEP: begin
        ga <= gb;
        gb <= div_r;
      end
      OP_E_BUMP: e <= e + 17'd2;
      OP_INV_INIT: begin
        r0 <= phi;
        r1 <= (32'(e) >= phi) ? 32'(e) - phi : 32'(e);
        t0 <= '0;
        t1 <= 34'sd1;
      end
      OP_INV_STEP: begin
        qt <= div_q;
        r0 <= r1;
        r1 <= div_r;
      end
      OP_INV_T: begin
        t0 <= t1;
        t1 <= t0 - 34'(prod);
      end
      OP_INV_FIX: begin
        if (phi == 32'd1) private_exponent <= '0;
        else if (t0 < 0) private_exponent <= 32'(t0 + $signed({2'b00, phi}));
        else private_exponent <= t0[31:0];
      end
      default: ;
    endcase
    if (cmd.op == OP_E_INIT || cmd.op == OP_E_BUMP) begin
      ga <= (cmd.op == OP_E_INIT) ? ((32'(EXP_DEFAULT) >= phi) ? 32'(EXP_SMALL) :
            32'(EXP_DEFAULT)) : 32'(e + 17'd2);
      gb <= phi;
    end
  end

  assign public_exponent = e;
  assign v_mult3 = is_mult3(v);

  always_comb begin
    sts = '0;
    sts.div_done       = div_done;
    sts.pr_small_prime = (v == 16'd2) || (v == 16'd3);
    sts.pr_small_comp  = (v < 16'd2) || ((v > 16'd3) && (!v[0] || v_mult3));
    sts.pr_loop_end    = ksq > 34'(v);
    sts.rem_zero       = div_r == '0;
    sts.gcd_b_zero     = gb == '0;
    sts.gcd_is_one     = ga == 32'd1;
    sts.inv_r1_zero    = r1 == '0;
    sts.inv_ok         = (r0 == 32'd1) || (phi == 32'd1);
  end
endmodule
`default_nettype wire

### src/rkg_controller.sv
// rkg_controller: sequencing state machine for primality, gcd and inverse steps
// depends on rkg_pkg
`default_nettype none
module rkg_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  output logic                done,
  output rkg_pkg::status_t    status,
  output rkg_pkg::dp_cmd_t    cmd,
  input  wire rkg_pkg::dp_status_t sts
);
  import rkg_pkg::*;

  ctl_state_t state, state_next;
  logic second, second_next;
  logic kp2, kp2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
      kp2    <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
      kp2    <= kp2_next;
    end
  end

  always_comb begin
    state_next    = state;
    second_next   = second;
    kp2_next      = kp2;
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.pr_second = second;
    cmd.divk2     = kp2;
    busy          = state != S_IDLE;
    done          = 1'b0;
    status        = ST_OK;
    case (state)
      S_IDLE: if (start) begin
        cmd.op      = OP_LOAD;
        second_next = 1'b0;
        state_next  = S_PR_INIT;
      end
      S_PR_INIT: begin
        cmd.op     = OP_PR_SEL;
        state_next = S_PR_SMALL;
      end
      S_PR_SMALL: begin
        if (sts.pr_small_comp) state_next = S_DONE_NP;
        else if (sts.pr_small_prime || sts.pr_loop_end) begin
          if (second) state_next = S_MUL;
          else begin
            second_next = 1'b1;
            state_next  = S_PR_INIT;
          end
        end else begin
          kp2_next   = 1'b0;
          state_next = S_PR_DIV;
        end
      end
      S_PR_DIV: begin
        cmd.op     = OP_PR_START;
        state_next = S_PR_WAIT;
      end
      S_PR_WAIT: if (sts.div_done) begin
        if (sts.rem_zero) state_next = S_DONE_NP;
        else if (!kp2) begin
          kp2_next   = 1'b1;
          state_next = S_PR_DIV;
        end else state_next = S_PR_NEXT;
      end
      S_PR_NEXT: begin
        cmd.op     = OP_PR_NEXT;
        kp2_next   = 1'b0;
        state_next = S_PR_SMALL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_E_INIT;
      end
      S_E_INIT: begin
        cmd.op     = OP_E_INIT;
        state_next = S_GCD_DIV;
      end
      S_GCD_DIV: begin
        if (sts.gcd_b_zero) begin
          if (sts.gcd_is_one) state_next = S_INV_INIT;
          else begin
            cmd.op = OP_E_BUMP;
          end
        end else begin
          cmd.op     = OP_GCD_START;
          state_next = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: if (sts.div_done) begin
        cmd.op     = OP_GCD_STEP;
        state_next = S_GCD_DIV;
      end
      S_INV_INIT: begin
        cmd.op     = OP_INV_INIT;
        state_next = S_INV_DIV;
      end
      S_INV_DIV: begin
        if (sts.inv_r1_zero) state_next = S_INV_FIX;
        else begin
          cmd.op     = OP_INV_START;
          state_next = S_INV_WAIT;
        end
      end
      S_INV_WAIT: if (sts.div_done) begin
        cmd.op     = OP_INV_STEP;
        state_next = S_INV_T;
      end
      S_INV_T: begin
        cmd.op     = OP_INV_T;
        state_next = S_INV_DIV;
      end
      S_INV_FIX: begin
        if (sts.inv_ok) begin
          cmd.op     = OP_INV_FIX;
          state_next = S_DONE_OK;
        end else state_next = S_DONE_NI;
      end
      S_DONE_OK: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      S_DONE_NP: begin
        done = 1'b1;
        status = ST_NOT_PRIME;
        state_next = S_IDLE;
      end
      S_DONE_NI: begin
        done = 1'b1;
        status = ST_NO_INV;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/rsa_key_generator_unit.sv
// rsa_key_generator_unit: top level joining controller and datapath
// depends on rkg_pkg, rkg_controller, rkg_datapath
// run time depends on the data, with two divides per trial divisor pair;
// one item at a time, busy high meanwhile, next start taken the cycle after done.
// the result is shown for one cycle with done; the receiver cannot stall.
// synchronous active-high reset returns the controller to idle.
`default_nettype none
module rsa_key_generator_unit #(
  parameter int unsigned PRIME_BITS = rkg_pkg::PRIME_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire rkg_pkg::in_item_t in_item,
  output logic              busy,
  output logic              done,
  output rkg_pkg::out_item_t out_item
);
  import rkg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;
  status_t    st;
  logic [31:0] n, d;
  logic [16:0] e;

  rkg_controller u_ctl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .status(st), .cmd(cmd), .sts(sts)
  );

  rkg_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd), .sts(sts),
    .modulus(n), .public_exponent(e), .private_exponent(d)
  );

  always_comb begin
    out_item.status           = st;
    out_item.modulus          = (st == ST_OK) ? n : '0;
    out_item.public_exponent  = (st == ST_OK) ? e : '0;
    out_item.private_exponent = (st == ST_OK) ? d : '0;
  end
endmodule
`default_nettype wire

### src/rkg_checker.sv
// rkg_checker: port-level assertions for rsa_key_generator_unit
// depends on rkg_pkg; bound to the top level below
`default_nettype none
module rkg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire rkg_pkg::out_item_t out_item
);
  import rkg_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done outside busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy) else $error("done not a single pulse");
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && out_item.status != ST_OK |-> out_item.modulus == '0 &&
    out_item.public_exponent == '0 && out_item.private_exponent == '0)
    else $error("fields nonzero on error status");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> out_item.status != 2'd3) else $error("bad status");
endmodule

bind rsa_key_generator_unit rkg_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .out_item(out_item)
);
`default_nettype wire

### tb/sv/rsa_key_generator_unit_checker.sv
// rsa_key_generator_unit_checker: watches the command and result channels,
// computes the expected key for every accepted transaction and compares it
// depends on rkg_pkg
`default_nettype none
module rsa_key_generator_unit_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire rkg_pkg::in_item_t  in_item,
  input  wire logic               done,
  input  wire rkg_pkg::out_item_t out_item,
  output int                      fail_count,
  output int                      keys_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rkg_pkg::*;

  out_item_t expected_keys[4];
  int key_wr = 0;
  int key_rd = 0;

  function automatic bit is_prime16(int unsigned v);
    int unsigned k;
    if (v < 2) return 1'b0;
    if (v == 2 || v == 3) return 1'b1;
    if (v % 2 == 0 || v % 3 == 0) return 1'b0;
    for (k = 5; k * k <= v; k += 6) begin
      if (v % k == 0 || v % (k + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic out_item_t derive_key(in_item_t item);
    out_item_t res;
    longint unsigned p, q, phi, e;
    longint r0, r1, t0, t1, qt, rn, tn;
    res = '0;
    p = item.prime_p;
    q = item.prime_q;
    if (!is_prime16(32'(p)) || !is_prime16(32'(q))) begin
      res.status = ST_NOT_PRIME;
      return res;
    end
    phi = (p - 1) * (q - 1);
    e = EXP_DEFAULT;
    if (e >= phi) e = EXP_SMALL;
    while (gcd64(e, phi) != 1) e += 2;
    r0 = phi;
    r1 = e % phi;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      rn = r0 - qt * r1;
      tn = t0 - qt * t1;
      r0 = r1;
      r1 = rn;
      t0 = t1;
      t1 = tn;
    end
    if (r0 != 1 && phi != 1) begin
      res.status = ST_NO_INV;
      return res;
    end
    res.status = ST_OK;
    res.modulus = 32'(p * q);
    res.public_exponent = 17'(e);
    res.private_exponent = 32'(((t0 % longint'(phi)) + longint'(phi)) % longint'(phi));
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign keys_pending = key_wr - key_rd;

  always @(posedge clk) begin
    out_item_t exp_key;
    if (!rst) begin
      if (done) begin
        if (key_wr == key_rd) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          exp_key = expected_keys[2'(key_rd)];
          key_rd++;
          if (out_item.status != exp_key.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_item.status, exp_key.status));
          if (out_item.modulus != exp_key.modulus)
            report_mismatch($sformatf("modulus %0d, expected %0d",
                                      out_item.modulus, exp_key.modulus));
          if (out_item.public_exponent != exp_key.public_exponent)
            report_mismatch($sformatf("public exponent %0d, expected %0d",
                                      out_item.public_exponent, exp_key.public_exponent));
          if (out_item.private_exponent != exp_key.private_exponent)
            report_mismatch($sformatf("private exponent %0d, expected %0d",
                                      out_item.private_exponent, exp_key.private_exponent));
        end
      end
      if (start && !busy) begin
        expected_keys[2'(key_wr)] = derive_key(in_item);
        key_wr++;
      end
    end
  end
endmodule
`default_nettype wire

### tb/sv/rsa_key_generator_unit_test.sv
// rsa_key_generator_unit_test: drives directed and random pairs, mostly prime,
// into the key generator; checking is done by rsa_key_generator_unit_checker
// depends on rkg_pkg, rsa_key_generator_unit, rsa_key_generator_unit_checker
`default_nettype none
module rsa_key_generator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rkg_pkg::*;

  localparam int STALL_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy, done;
  out_item_t out_item;
  int fail_count, keys_pending;
  int stall_cycles = 0;
  int n;

  rsa_key_generator_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .out_item(out_item)
  );

  rsa_key_generator_unit_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_item(in_item),
    .done(done), .out_item(out_item), .fail_count(fail_count),
    .keys_pending(keys_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("rsa_key_generator_unit test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // largest prime not above v, v >= 2
  function automatic logic [15:0] prime_below(int unsigned v);
    int unsigned k;
    bit ok;
    for (; v > 2; v--) begin
      ok = (v % 2 != 0);
      for (k = 3; ok && k * k <= v; k += 2) if (v % k == 0) ok = 1'b0;
      if (ok) return 16'(v);
    end
    return 16'd2;
  endfunction

  function automatic logic [15:0] rand_prime();
    if ($urandom_range(99) < 75) return prime_below($urandom_range(255, 2));
    return prime_below($urandom_range(65535, 2));
  endfunction

  task automatic send_pair(logic [15:0] p, logic [15:0] q, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 24) @(negedge clk);
    end
    while (busy) @(negedge clk);
    in_item.prime_p = p;
    in_item.prime_q = q;
    start = 1'b1;
    @(posedge clk);
    @(negedge clk);
    start = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_pair(16'd0, 16'd0, 1'b0);
    send_pair(16'd1, 16'd1, 1'b0);
    send_pair(16'd2, 16'd2, 1'b0);
    send_pair(16'd2, 16'd3, 1'b1);
    send_pair(16'd3, 16'd2, 1'b1);
    send_pair(16'd3, 16'd3, 1'b0);
    send_pair(16'd5, 16'd7, 1'b1);
    send_pair(16'd4, 16'd7, 1'b0);
    send_pair(16'd7, 16'd9, 1'b0);
    send_pair(16'd25, 16'd7, 1'b1);
    send_pair(16'd0, 16'd2, 1'b0);
    send_pair(16'd1, 16'd65521, 1'b0);
    send_pair(16'hffff, 16'hffff, 1'b1);
    send_pair(16'hffff, 16'd0, 1'b0);
    send_pair(16'haaaa, 16'h5555, 1'b1);
    send_pair(16'd65521, 16'd65521, 1'b0);
    send_pair(16'd65521, 16'd65519, 1'b1);
    send_pair(16'd257, 16'd65535, 1'b0);
    send_pair(16'd257, 16'd257, 1'b0);
    send_pair(16'd3, 16'd11, 1'b1);

    for (n = 0; n < 130; n++) begin
      if ($urandom_range(99) < 80) begin
        send_pair(rand_prime(), rand_prime(), !(n >= 50 && n < 90));
      end else begin
        send_pair(16'($urandom), 16'($urandom), !(n >= 50 && n < 90));
      end
    end

    while (keys_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("rsa_key_generator_unit test passed");
    end else begin
      $display("rsa_key_generator_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
